// ===== rtl/tlc_pkg.sv =====
// ----------------------------------------------------------------------------
// tlc_pkg
// Shared constants, payload words, row types and controller/datapath links
// for the two-level cache tag model.
// ----------------------------------------------------------------------------
package tlc_pkg;

    localparam int L1I_SETS = 64;
    localparam int L1I_WAYS = 4;
    localparam int L1D_SETS = 64;
    localparam int L1D_WAYS = 4;
    localparam int L2_SETS  = 512;
    localparam int L2_WAYS  = 8;

    localparam int MAX_WAYS = 16;
    localparam int WAY_W    = 4;

    function automatic int floor_log2(input int n);
        int b;
        b = 0;
        for (int k = 0; k < 31; k++) begin
            if ((n >> (k + 1)) != 0) begin
                b = k + 1;
            end
        end
        return b;
    endfunction

    localparam int L1I_IB    = floor_log2(L1I_SETS);
    localparam int L1I_AW    = (L1I_IB > 0) ? L1I_IB : 1;
    localparam int L1I_DEPTH = 1 << L1I_IB;
    localparam int L1D_IB    = floor_log2(L1D_SETS);
    localparam int L1D_AW    = (L1D_IB > 0) ? L1D_IB : 1;
    localparam int L1D_DEPTH = 1 << L1D_IB;
    localparam int L2_IB     = floor_log2(L2_SETS);
    localparam int L2_AW     = (L2_IB > 0) ? L2_IB : 1;
    localparam int L2_DEPTH  = 1 << L2_IB;

    localparam int CLR_DEPTH0 = (L1I_DEPTH > L1D_DEPTH) ? L1I_DEPTH : L1D_DEPTH;
    localparam int CLR_DEPTH  = (L2_DEPTH > CLR_DEPTH0) ? L2_DEPTH : CLR_DEPTH0;
    localparam int CLR_AW     = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int TIME_W     = 11;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_L1I_HIT_TIME  = 3'd0,
        CFG_L1D_HIT_TIME  = 3'd1,
        CFG_L2_HIT_TIME   = 3'd2,
        CFG_MEM_LATENCY   = 3'd3,
        CFG_INCLUSIVE     = 3'd4,
        CFG_BLOCK_OFFSET  = 3'd5,
        CFG_LEVEL_ENABLE  = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic        op;
        logic [31:0] addr;
    } in_word_t;

    typedef struct packed {
        logic [TIME_W-1:0] access_time;
        logic              l1_hit;
        logic              l2_used;
        logic              l2_hit;
    } out_word_t;

    typedef struct packed {
        logic [L1I_WAYS-1:0]       valid;
        logic [L1I_WAYS-1:0][31:0] tag;
        logic [L1I_WAYS-1:0][31:0] stamp;
    } l1i_row_t;

    typedef struct packed {
        logic [L1D_WAYS-1:0]       valid;
        logic [L1D_WAYS-1:0][31:0] tag;
        logic [L1D_WAYS-1:0][31:0] stamp;
    } l1d_row_t;

    typedef struct packed {
        logic [L2_WAYS-1:0]       valid;
        logic [L2_WAYS-1:0][31:0] tag;
        logic [L2_WAYS-1:0][31:0] stamp;
        logic [L2_WAYS-1:0][31:0] baddr;
    } l2_row_t;

    typedef struct packed {
        logic             hit;
        logic [WAY_W-1:0] way;
    } way_sel_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_INV_RD,
        ST_INV_WR,
        ST_FILL_RD,
        ST_FILL_WR,
        ST_DONE
    } tlc_state_t;

    typedef struct packed {
        logic clear;
        logic capture;
        logic look;
        logic inv_rd;
        logic inv_wr;
        logic fill_rd;
        logic fill_wr;
        logic out_load;
    } tlc_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic inv_need;
        logic fill_pend;
        logic out_free;
    } tlc_sts_t;

endpackage

// ===== rtl/tlc_ctrl.sv =====
// ----------------------------------------------------------------------------
// tlc_ctrl
// Sequencer: clear pass, lookup, back-invalidation, deferred L1 fill, output.
// ----------------------------------------------------------------------------
module tlc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  tlc_pkg::tlc_sts_t sts,
    output tlc_pkg::tlc_cmd_t cmd
);

    tlc_pkg::tlc_state_t state_reg;
    tlc_pkg::tlc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tlc_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            tlc_pkg::ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = tlc_pkg::ST_IDLE;
                end
            end
            tlc_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = tlc_pkg::ST_LOOK;
                end
            end
            tlc_pkg::ST_LOOK:
            begin
                cmd.look   = 1'b1;
                state_next = sts.inv_need ? tlc_pkg::ST_INV_RD : tlc_pkg::ST_DONE;
            end
            tlc_pkg::ST_INV_RD:
            begin
                cmd.inv_rd = 1'b1;
                state_next = tlc_pkg::ST_INV_WR;
            end
            tlc_pkg::ST_INV_WR:
            begin
                cmd.inv_wr = 1'b1;
                state_next = sts.fill_pend ? tlc_pkg::ST_FILL_RD : tlc_pkg::ST_DONE;
            end
            tlc_pkg::ST_FILL_RD:
            begin
                cmd.fill_rd = 1'b1;
                state_next  = tlc_pkg::ST_FILL_WR;
            end
            tlc_pkg::ST_FILL_WR:
            begin
                cmd.fill_wr = 1'b1;
                state_next  = tlc_pkg::ST_DONE;
            end
            tlc_pkg::ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = tlc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tlc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/tlc_dp.sv =====
// ----------------------------------------------------------------------------
// tlc_dp
// Tag stores (one row per set), LRU/victim logic, counters, config, output.
// ----------------------------------------------------------------------------
module tlc_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tlc_pkg::in_word_t                   in_data,
    input  logic                                cfg_we,
    input  logic [tlc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tlc_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output tlc_pkg::out_word_t                  out_data,
    input  tlc_pkg::tlc_cmd_t                   cmd,
    output tlc_pkg::tlc_sts_t                   sts
);

    // configuration
    logic [7:0] l1i_time_reg, l1d_time_reg, l2_time_reg;
    logic [9:0] mem_lat_reg;
    logic       incl_reg;
    logic [2:0] off_reg;
    logic [2:0] en_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l1i_time_reg <= 8'd1;
            l1d_time_reg <= 8'd1;
            l2_time_reg  <= 8'd10;
            mem_lat_reg  <= 10'd100;
            incl_reg     <= 1'b0;
            off_reg      <= 3'd6;
            en_reg       <= 3'd7;
        end
        else if (cfg_we)
        begin
            case (tlc_pkg::cfg_idx_t'(cfg_index))
                tlc_pkg::CFG_L1I_HIT_TIME: l1i_time_reg <= cfg_data[7:0];
                tlc_pkg::CFG_L1D_HIT_TIME: l1d_time_reg <= cfg_data[7:0];
                tlc_pkg::CFG_L2_HIT_TIME:  l2_time_reg  <= cfg_data[7:0];
                tlc_pkg::CFG_MEM_LATENCY:  mem_lat_reg  <= cfg_data;
                tlc_pkg::CFG_INCLUSIVE:    incl_reg     <= cfg_data[0];
                tlc_pkg::CFG_BLOCK_OFFSET: off_reg      <= cfg_data[2:0];
                tlc_pkg::CFG_LEVEL_ENABLE: en_reg       <= cfg_data[2:0];
                default:                   ;
            endcase
        end
    end

    // address split helpers
    function automatic logic [tlc_pkg::L1I_AW-1:0] set_i(input logic [31:0] a,
                                                         input logic [2:0] off);
        logic [31:0] b;
        b = a >> off;
        return tlc_pkg::L1I_AW'(b & 32'(tlc_pkg::L1I_DEPTH - 1));
    endfunction

    function automatic logic [tlc_pkg::L1D_AW-1:0] set_d(input logic [31:0] a,
                                                         input logic [2:0] off);
        logic [31:0] b;
        b = a >> off;
        return tlc_pkg::L1D_AW'(b & 32'(tlc_pkg::L1D_DEPTH - 1));
    endfunction

    function automatic logic [tlc_pkg::L2_AW-1:0] set_2(input logic [31:0] a,
                                                        input logic [2:0] off);
        logic [31:0] b;
        b = a >> off;
        return tlc_pkg::L2_AW'(b & 32'(tlc_pkg::L2_DEPTH - 1));
    endfunction

    function automatic tlc_pkg::way_sel_t find_hit(
        input logic [tlc_pkg::MAX_WAYS-1:0]       v,
        input logic [tlc_pkg::MAX_WAYS-1:0][31:0] t,
        input logic [31:0]                        tag,
        input int                                 ways);
        tlc_pkg::way_sel_t r;
        r = '0;
        for (int j = tlc_pkg::MAX_WAYS - 1; j >= 0; j--)
        begin
            if (j < ways && v[j] && t[j] == tag)
            begin
                r.hit = 1'b1;
                r.way = tlc_pkg::WAY_W'(j);
            end
        end
        return r;
    endfunction

    // hit field flags an eviction; way is the chosen victim
    function automatic tlc_pkg::way_sel_t find_victim(
        input logic [tlc_pkg::MAX_WAYS-1:0]       v,
        input logic [tlc_pkg::MAX_WAYS-1:0][31:0] s,
        input int                                 ways);
        tlc_pkg::way_sel_t r;
        logic              found;
        logic [31:0]       best;
        found = 1'b0;
        r     = '0;
        for (int j = tlc_pkg::MAX_WAYS - 1; j >= 0; j--)
        begin
            if (j < ways && !v[j])
            begin
                found = 1'b1;
                r.way = tlc_pkg::WAY_W'(j);
            end
        end
        if (!found)
        begin
            r.hit = 1'b1;
            r.way = '0;
            best  = s[0];
            for (int j = 1; j < tlc_pkg::MAX_WAYS; j++)
            begin
                if (j < ways && s[j] < best)
                begin
                    best  = s[j];
                    r.way = tlc_pkg::WAY_W'(j);
                end
            end
        end
        return r;
    endfunction

    // item registers
    logic        op_reg;
    logic [31:0] addr_reg;
    logic [31:0] old_reg;
    logic        fill_pend_reg;
    logic [31:0] l1i_ref_reg, l1d_ref_reg, l2_ref_reg;
    logic [tlc_pkg::TIME_W-1:0] time_reg;
    logic        l1_hit_reg, l2_used_reg, l2_hit_reg;
    logic [tlc_pkg::CLR_AW-1:0] clr_reg;
    logic        out_valid_reg;
    tlc_pkg::out_word_t out_data_reg;

    // memories
    tlc_pkg::l1i_row_t l1i_mem [tlc_pkg::L1I_DEPTH];
    tlc_pkg::l1d_row_t l1d_mem [tlc_pkg::L1D_DEPTH];
    tlc_pkg::l2_row_t  l2_mem  [tlc_pkg::L2_DEPTH];
    tlc_pkg::l1i_row_t i_q_reg;
    tlc_pkg::l1d_row_t d_q_reg;
    tlc_pkg::l2_row_t  l2_q_reg;

    logic                      i_re, i_we, d_re, d_we, l2_re, l2_we;
    logic [tlc_pkg::L1I_AW-1:0] i_ra, i_wa;
    logic [tlc_pkg::L1D_AW-1:0] d_ra, d_wa;
    logic [tlc_pkg::L2_AW-1:0]  l2_ra, l2_wa;
    tlc_pkg::l1i_row_t          i_wd;
    tlc_pkg::l1d_row_t          d_wd;
    tlc_pkg::l2_row_t           l2_wd;

    always_ff @(posedge clk)
    begin
        if (i_we)
        begin
            l1i_mem[i_wa] <= i_wd;
        end
        if (i_re)
        begin
            i_q_reg <= l1i_mem[i_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_we)
        begin
            l1d_mem[d_wa] <= d_wd;
        end
        if (d_re)
        begin
            d_q_reg <= l1d_mem[d_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (l2_we)
        begin
            l2_mem[l2_wa] <= l2_wd;
        end
        if (l2_re)
        begin
            l2_q_reg <= l2_mem[l2_ra];
        end
    end

    // widen rows to the common way count
    logic [tlc_pkg::MAX_WAYS-1:0]       iv, dv, v2;
    logic [tlc_pkg::MAX_WAYS-1:0][31:0] it, is_, dt, ds, t2, s2, b2;
    logic [tlc_pkg::MAX_WAYS-1:0]       ov, mv, xiv, xdv, nv2;
    logic [tlc_pkg::MAX_WAYS-1:0][31:0] ot, os, mt, ms, xit, xdt, nt2, ns2, nb2;
    logic [31:0] blk, blk_old, o_tag, i_tag_old, d_tag_old, l2_tag, ref_sel, ref_n, stamp1;
    int          o_ways;
    tlc_pkg::way_sel_t h1, vc1, h2, vc2;
    logic        en1, en2, l2go, inv_need;
    logic [tlc_pkg::TIME_W-1:0] l1t, l2part, t_sum;
    logic        clr_i, clr_d, clr_2;

    always_comb
    begin
        iv = '0; it = '0; is_ = '0;
        dv = '0; dt = '0; ds = '0;
        v2 = '0; t2 = '0; s2 = '0; b2 = '0;
        for (int j = 0; j < tlc_pkg::L1I_WAYS; j++)
        begin
            iv[j]  = i_q_reg.valid[j];
            it[j]  = i_q_reg.tag[j];
            is_[j] = i_q_reg.stamp[j];
        end
        for (int j = 0; j < tlc_pkg::L1D_WAYS; j++)
        begin
            dv[j] = d_q_reg.valid[j];
            dt[j] = d_q_reg.tag[j];
            ds[j] = d_q_reg.stamp[j];
        end
        for (int j = 0; j < tlc_pkg::L2_WAYS; j++)
        begin
            v2[j] = l2_q_reg.valid[j];
            t2[j] = l2_q_reg.tag[j];
            s2[j] = l2_q_reg.stamp[j];
            b2[j] = l2_q_reg.baddr[j];
        end
    end

    always_comb
    begin
        blk       = addr_reg >> off_reg;
        blk_old   = old_reg >> off_reg;
        i_tag_old = blk_old >> tlc_pkg::L1I_IB;
        d_tag_old = blk_old >> tlc_pkg::L1D_IB;
        l2_tag    = blk >> tlc_pkg::L2_IB;
        en1       = op_reg ? en_reg[1] : en_reg[0];
        en2       = en_reg[2];

        // selected first level
        ov     = op_reg ? dv : iv;
        ot     = op_reg ? dt : it;
        os     = op_reg ? ds : is_;
        o_ways = op_reg ? tlc_pkg::L1D_WAYS : tlc_pkg::L1I_WAYS;
        o_tag  = op_reg ? (blk >> tlc_pkg::L1D_IB) : (blk >> tlc_pkg::L1I_IB);
        h1     = find_hit(ov, ot, o_tag, o_ways);
        vc1    = find_victim(ov, os, o_ways);
        ref_sel = op_reg ? l1d_ref_reg : l1i_ref_reg;
        ref_n   = ref_sel + 32'd1;
        stamp1  = cmd.look ? ref_n : ref_sel;
        mv = ov; mt = ot; ms = os;
        if (cmd.look && h1.hit)
        begin
            ms[h1.way] = stamp1;
        end
        else
        begin
            mv[vc1.way] = 1'b1;
            mt[vc1.way] = o_tag;
            ms[vc1.way] = stamp1;
        end

        // second level
        l2go = en2 && (!en1 || !h1.hit);
        h2   = find_hit(v2, t2, l2_tag, tlc_pkg::L2_WAYS);
        vc2  = find_victim(v2, s2, tlc_pkg::L2_WAYS);
        nv2 = v2; nt2 = t2; ns2 = s2; nb2 = b2;
        if (h2.hit)
        begin
            ns2[h2.way] = l2_ref_reg + 32'd1;
        end
        else
        begin
            nv2[vc2.way] = 1'b1;
            nt2[vc2.way] = l2_tag;
            ns2[vc2.way] = l2_ref_reg + 32'd1;
            nb2[vc2.way] = addr_reg;
        end
        inv_need = l2go && !h2.hit && vc2.hit && incl_reg && (en_reg[0] || en_reg[1]);

        // back-invalidation of both first levels
        xiv = iv; xit = it;
        xdv = dv; xdt = dt;
        for (int j = 0; j < tlc_pkg::MAX_WAYS; j++)
        begin
            if (iv[j] && it[j] == i_tag_old)
            begin
                xiv[j] = 1'b0;
                xit[j] = '0;
            end
            if (dv[j] && dt[j] == d_tag_old)
            begin
                xdv[j] = 1'b0;
                xdt[j] = '0;
            end
        end

        // latency
        l1t    = tlc_pkg::TIME_W'(op_reg ? l1d_time_reg : l1i_time_reg);
        l2part = tlc_pkg::TIME_W'(l2_time_reg)
               + (h2.hit ? '0 : tlc_pkg::TIME_W'(mem_lat_reg));
        if (en1 && h1.hit)
        begin
            t_sum = l1t;
        end
        else if (en1 && en2)
        begin
            t_sum = l1t + l2part;
        end
        else if (en1)
        begin
            t_sum = l1t + tlc_pkg::TIME_W'(mem_lat_reg);
        end
        else if (en2)
        begin
            t_sum = l2part;
        end
        else
        begin
            t_sum = tlc_pkg::TIME_W'(mem_lat_reg);
        end
    end

    // memory ports
    always_comb
    begin
        clr_i = ({1'b0, clr_reg} < (tlc_pkg::CLR_AW + 1)'(tlc_pkg::L1I_DEPTH));
        clr_d = ({1'b0, clr_reg} < (tlc_pkg::CLR_AW + 1)'(tlc_pkg::L1D_DEPTH));
        clr_2 = ({1'b0, clr_reg} < (tlc_pkg::CLR_AW + 1)'(tlc_pkg::L2_DEPTH));

        i_re = cmd.capture || cmd.inv_rd || cmd.fill_rd;
        d_re = i_re;
        l2_re = cmd.capture;
        i_ra = cmd.capture ? set_i(in_data.addr, off_reg)
             : cmd.inv_rd  ? set_i(old_reg, off_reg) : set_i(addr_reg, off_reg);
        d_ra = cmd.capture ? set_d(in_data.addr, off_reg)
             : cmd.inv_rd  ? set_d(old_reg, off_reg) : set_d(addr_reg, off_reg);
        l2_ra = set_2(in_data.addr, off_reg);

        i_we = (cmd.clear && clr_i)
            || (cmd.look && !op_reg && en1 && (h1.hit || !inv_need))
            || (cmd.inv_wr && en_reg[0])
            || (cmd.fill_wr && !op_reg);
        d_we = (cmd.clear && clr_d)
            || (cmd.look && op_reg && en1 && (h1.hit || !inv_need))
            || (cmd.inv_wr && en_reg[1])
            || (cmd.fill_wr && op_reg);
        l2_we = (cmd.clear && clr_2) || (cmd.look && l2go);

        i_wa = cmd.clear ? clr_reg[tlc_pkg::L1I_AW-1:0]
             : cmd.inv_wr ? set_i(old_reg, off_reg) : set_i(addr_reg, off_reg);
        d_wa = cmd.clear ? clr_reg[tlc_pkg::L1D_AW-1:0]
             : cmd.inv_wr ? set_d(old_reg, off_reg) : set_d(addr_reg, off_reg);
        l2_wa = cmd.clear ? clr_reg[tlc_pkg::L2_AW-1:0] : set_2(addr_reg, off_reg);

        i_wd = '0;
        d_wd = '0;
        l2_wd = '0;
        if (!cmd.clear)
        begin
            for (int j = 0; j < tlc_pkg::L1I_WAYS; j++)
            begin
                i_wd.valid[j] = cmd.inv_wr ? xiv[j] : mv[j];
                i_wd.tag[j]   = cmd.inv_wr ? xit[j] : mt[j];
                i_wd.stamp[j] = cmd.inv_wr ? is_[j] : ms[j];
            end
            for (int j = 0; j < tlc_pkg::L1D_WAYS; j++)
            begin
                d_wd.valid[j] = cmd.inv_wr ? xdv[j] : mv[j];
                d_wd.tag[j]   = cmd.inv_wr ? xdt[j] : mt[j];
                d_wd.stamp[j] = cmd.inv_wr ? ds[j] : ms[j];
            end
            for (int j = 0; j < tlc_pkg::L2_WAYS; j++)
            begin
                l2_wd.valid[j] = nv2[j];
                l2_wd.tag[j]   = nt2[j];
                l2_wd.stamp[j] = ns2[j];
                l2_wd.baddr[j] = nb2[j];
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            l1i_ref_reg   <= '0;
            l1d_ref_reg   <= '0;
            l2_ref_reg    <= '0;
            fill_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_reg <= clr_reg + tlc_pkg::CLR_AW'(1);
            end
            if (cmd.look)
            begin
                if (en1 && !op_reg)
                begin
                    l1i_ref_reg <= ref_n;
                end
                if (en1 && op_reg)
                begin
                    l1d_ref_reg <= ref_n;
                end
                if (l2go)
                begin
                    l2_ref_reg <= l2_ref_reg + 32'd1;
                end
                fill_pend_reg <= en1 && !h1.hit;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= in_data.op;
            addr_reg <= in_data.addr;
        end
        if (cmd.look)
        begin
            old_reg     <= b2[vc2.way];
            time_reg    <= t_sum;
            l1_hit_reg  <= en1 && h1.hit;
            l2_used_reg <= l2go;
            l2_hit_reg  <= l2go && h2.hit;
        end
        if (cmd.out_load)
        begin
            out_data_reg.access_time <= time_reg;
            out_data_reg.l1_hit      <= l1_hit_reg;
            out_data_reg.l2_used     <= l2_used_reg;
            out_data_reg.l2_hit      <= l2_hit_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;
    assign sts.clr_last  = (clr_reg == tlc_pkg::CLR_AW'(tlc_pkg::CLR_DEPTH - 1));
    assign sts.inv_need  = inv_need;
    assign sts.fill_pend = fill_pend_reg;
    assign sts.out_free  = !out_valid_reg || !out_stall;

endmodule

// ===== rtl/two_level_cache_lru_tag_model.sv =====
// ----------------------------------------------------------------------------
// two_level_cache_lru_tag_model
// Tag model of split L1 instruction/data caches over a shared L2, each
// set-associative with timestamp LRU and optional inclusive back-invalidation.
// ----------------------------------------------------------------------------
//
//   channel | handshake          | word
//   --------+--------------------+-------------------------------------------
//   in      | in_valid/in_stall  | op, addr
//   out     | out_valid/out_stall| access_time, l1_hit, l2_used, l2_hit
//   cfg     | cfg_we             | cfg_index, cfg_data (write only)
//
// An access steps through accept, lookup and output. An L2 replacement that
// back-invalidates adds an invalidation read and write, plus, after an L1
// miss, a re-read and write to refill L1 from its set; each tag row memory
// has one registered read port and one write port. One access is in flight.
// After reset a clearing pass writes every tag row with the input held
// stalled; configuration writes are taken throughout.
// The output register lets a new word be accepted while a result waits;
// a stalled result holds, and the sequencer waits before loading the next.
//
module two_level_cache_lru_tag_model (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  tlc_pkg::in_word_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output tlc_pkg::out_word_t                  out_data,
    input  logic                                cfg_we,
    input  logic [tlc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tlc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    // command and status between sequencer and datapath
    tlc_pkg::tlc_cmd_t cmd;
    tlc_pkg::tlc_sts_t sts;

    tlc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // tag rows, victim choice, counters, config and the output register
    tlc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// ===== verif/two_level_cache_lru_tag_model_test.sv =====
// ----------------------------------------------------------------------------
// two_level_cache_lru_tag_model_test
// Drives random and directed accesses into the two-level cache tag model,
// predicts every result word with an independent LRU tag-store model and
// compares each output word with the next expected one, in order.
// ----------------------------------------------------------------------------
module two_level_cache_lru_tag_model_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;

    // ------------------------------------------------------------------
    // Cache tag predictor plus the queue of expected result words.
    // ------------------------------------------------------------------
    class cache_scoreboard;
        bit        i_valid [tlc_pkg::L1I_SETS*tlc_pkg::L1I_WAYS];
        bit [31:0] i_tag   [tlc_pkg::L1I_SETS*tlc_pkg::L1I_WAYS];
        bit [31:0] i_stamp [tlc_pkg::L1I_SETS*tlc_pkg::L1I_WAYS];
        bit        d_valid [tlc_pkg::L1D_SETS*tlc_pkg::L1D_WAYS];
        bit [31:0] d_tag   [tlc_pkg::L1D_SETS*tlc_pkg::L1D_WAYS];
        bit [31:0] d_stamp [tlc_pkg::L1D_SETS*tlc_pkg::L1D_WAYS];
        bit        u_valid [tlc_pkg::L2_SETS*tlc_pkg::L2_WAYS];
        bit [31:0] u_tag   [tlc_pkg::L2_SETS*tlc_pkg::L2_WAYS];
        bit [31:0] u_stamp [tlc_pkg::L2_SETS*tlc_pkg::L2_WAYS];
        bit [31:0] u_baddr [tlc_pkg::L2_SETS*tlc_pkg::L2_WAYS];
        bit [31:0] i_count, d_count, u_count;

        bit [7:0]  i_time, d_time, u_time;
        bit [9:0]  mem_time;
        bit        inclusive;
        bit [2:0]  offset_bits;
        bit [2:0]  enables;

        tlc_pkg::out_word_t pending_words[$];
        int        mismatches;

        function new();
            i_time = 1; d_time = 1; u_time = 10; mem_time = 100;
            inclusive = 0; offset_bits = 6; enables = 3'b111;
            mismatches = 0;
        endfunction

        function void set_reg(tlc_pkg::cfg_idx_t idx, bit [9:0] v);
            case (idx)
                tlc_pkg::CFG_L1I_HIT_TIME: i_time = v[7:0];
                tlc_pkg::CFG_L1D_HIT_TIME: d_time = v[7:0];
                tlc_pkg::CFG_L2_HIT_TIME:  u_time = v[7:0];
                tlc_pkg::CFG_MEM_LATENCY:  mem_time = v;
                tlc_pkg::CFG_INCLUSIVE:    inclusive = v[0];
                tlc_pkg::CFG_BLOCK_OFFSET: offset_bits = v[2:0];
                tlc_pkg::CFG_LEVEL_ENABLE: enables = v[2:0];
                default: ;
            endcase
        endfunction

        function int ways_of(int lvl);
            return (lvl == 2) ? tlc_pkg::L2_WAYS
                 : (lvl == 1) ? tlc_pkg::L1D_WAYS : tlc_pkg::L1I_WAYS;
        endfunction

        // Split an address into a set base line and a tag for a level.
        function void split(int lvl, bit [31:0] a, output int base, output bit [31:0] tg);
            int ib, ways;
            bit [31:0] blk;
            ib   = (lvl == 2) ? tlc_pkg::L2_IB
                 : (lvl == 1) ? tlc_pkg::L1D_IB : tlc_pkg::L1I_IB;
            ways = ways_of(lvl);
            blk  = a >> offset_bits;
            base = int'(blk & ((32'd1 << ib) - 1)) * ways;
            tg   = blk >> ib;
        endfunction

        function bit lookup(int lvl, bit [31:0] a, bit [31:0] st);
            int base, ways;
            bit [31:0] tg;
            split(lvl, a, base, tg);
            ways = ways_of(lvl);
            for (int j = 0; j < ways; j++)
            begin
                if (lvl == 0 && i_valid[base+j] && i_tag[base+j] == tg)
                begin
                    i_stamp[base+j] = st;
                    return 1;
                end
                if (lvl == 1 && d_valid[base+j] && d_tag[base+j] == tg)
                begin
                    d_stamp[base+j] = st;
                    return 1;
                end
                if (lvl == 2 && u_valid[base+j] && u_tag[base+j] == tg)
                begin
                    u_stamp[base+j] = st;
                    return 1;
                end
            end
            return 0;
        endfunction

        // Fill a line; pick the lowest invalid way, else the oldest stamp.
        function void fill(int lvl, bit [31:0] a, bit [31:0] st,
                           output bit evicted, output bit [31:0] victim);
            int base, ways, w;
            bit [31:0] tg, best, s;
            bit v, found;
            split(lvl, a, base, tg);
            ways = ways_of(lvl);
            found = 0; w = 0; evicted = 0; victim = 0;
            for (int j = 0; j < ways; j++)
            begin
                v = (lvl == 0) ? i_valid[base+j] : (lvl == 1) ? d_valid[base+j]
                                                              : u_valid[base+j];
                if (!v && !found)
                begin
                    w = j;
                    found = 1;
                end
            end
            if (!found)
            begin
                for (int j = 0; j < ways; j++)
                begin
                    s = (lvl == 0) ? i_stamp[base+j] : (lvl == 1) ? d_stamp[base+j]
                                                                  : u_stamp[base+j];
                    if (j == 0 || s < best)
                    begin
                        best = s;
                        w = j;
                    end
                end
                evicted = 1;
                if (lvl == 2) victim = u_baddr[base+w];
            end
            case (lvl)
                0:
                begin
                    i_valid[base+w] = 1; i_tag[base+w] = tg; i_stamp[base+w] = st;
                end
                1:
                begin
                    d_valid[base+w] = 1; d_tag[base+w] = tg; d_stamp[base+w] = st;
                end
                default:
                begin
                    u_valid[base+w] = 1; u_tag[base+w] = tg;
                    u_stamp[base+w] = st; u_baddr[base+w] = a;
                end
            endcase
        endfunction

        function void drop_copies(int lvl, bit [31:0] a);
            int base, ways;
            bit [31:0] tg;
            split(lvl, a, base, tg);
            ways = ways_of(lvl);
            for (int j = 0; j < ways; j++)
            begin
                if (lvl == 0 && i_valid[base+j] && i_tag[base+j] == tg)
                begin
                    i_valid[base+j] = 0;
                    i_tag[base+j] = 0;
                end
                if (lvl == 1 && d_valid[base+j] && d_tag[base+j] == tg)
                begin
                    d_valid[base+j] = 0;
                    d_tag[base+j] = 0;
                end
            end
        endfunction

        function void fill_shared(bit [31:0] a);
            bit ev;
            bit [31:0] old;
            fill(2, a, u_count, ev, old);
            if (ev && inclusive)
            begin
                if (enables[0]) drop_copies(0, old);
                if (enables[1]) drop_copies(1, old);
            end
        endfunction

        // Note an accepted access and queue its expected result.
        function void note_access(tlc_pkg::in_word_t w);
            tlc_pkg::out_word_t r;
            bit l1en, l2en, ev;
            bit [31:0] old, ref1;
            bit [10:0] t, l1t, ut, mt;
            int lv;
            lv   = w.op ? 1 : 0;
            l1en = enables[lv];
            l2en = enables[2];
            l1t  = 11'(w.op ? d_time : i_time);
            ut   = 11'(u_time);
            mt   = 11'(mem_time);
            r = '0;
            if (l1en)
            begin
                if (w.op)
                begin
                    d_count++;
                    ref1 = d_count;
                end
                else
                begin
                    i_count++;
                    ref1 = i_count;
                end
                r.l1_hit = lookup(lv, w.addr, ref1);
                if (r.l1_hit)
                begin
                    t = l1t;
                end
                else if (l2en)
                begin
                    u_count++;
                    r.l2_used = 1;
                    r.l2_hit = lookup(2, w.addr, u_count);
                    t = l1t + ut + (r.l2_hit ? 11'd0 : mt);
                    if (!r.l2_hit) fill_shared(w.addr);
                    fill(lv, w.addr, ref1, ev, old);
                end
                else
                begin
                    t = l1t + mt;
                    fill(lv, w.addr, ref1, ev, old);
                end
            end
            else if (l2en)
            begin
                u_count++;
                r.l2_used = 1;
                r.l2_hit = lookup(2, w.addr, u_count);
                t = ut + (r.l2_hit ? 11'd0 : mt);
                if (!r.l2_hit) fill_shared(w.addr);
            end
            else
            begin
                t = mt;
            end
            r.access_time = t;
            pending_words.push_back(r);
        endfunction

        function void check_result(tlc_pkg::out_word_t got);
            tlc_pkg::out_word_t exp_w;
            if (pending_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", got);
                return;
            end
            exp_w = pending_words.pop_front();
            if (got !== exp_w)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: exp time=%0d l1=%b l2u=%b l2h=%b",
                              " got time=%0d l1=%b l2u=%b l2h=%b"},
                             exp_w.access_time, exp_w.l1_hit, exp_w.l2_used, exp_w.l2_hit,
                             got.access_time, got.l1_hit, got.l2_used, got.l2_hit);
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    tlc_pkg::in_word_t  in_data;
    logic      out_valid;
    logic      out_stall;
    tlc_pkg::out_word_t out_data;
    logic      cfg_we;
    logic [tlc_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [tlc_pkg::CFG_DATA_W-1:0] cfg_data;

    cache_scoreboard sb;
    int  idle_cycles;
    bit  stim_done;
    bit  hold_off;      // receiver long hold-off request
    bit  no_gaps;       // phases without random idling
    bit [31:0] hot_addrs[16];

    two_level_cache_lru_tag_model u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Write one register; only called while nothing is in flight.
    // The enable stays high across back-to-back writes; the next access drops it.
    task automatic write_reg(tlc_pkg::cfg_idx_t idx, bit [9:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        sb.set_reg(idx, v);
    endtask

    // Offer one access word and hold it until it is taken.
    // Valid stays high after the accept; the next call or drain() drops it.
    task automatic send_access(bit op, bit [31:0] a);
        int gap;
        tlc_pkg::in_word_t w;
        gap = no_gaps ? 0 : $urandom_range(0, 13);
        cfg_we <= 1'b0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        w.op = op;
        w.addr = a;
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge clk); while (in_stall);
        sb.note_access(w);
    endtask

    // Wait until every expected word is back, then let the sequencer settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_words.size() != 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    // Address with few distinct tags per set so that hits and evictions happen.
    function automatic bit [31:0] pick_addr();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) return hot_addrs[$urandom_range(0, 15)]
                           ^ ($urandom_range(0, 3) << 6);
        if (sel < 9) return {6'd0, 5'($urandom_range(0, 31)), 6'd0,
                             3'($urandom_range(0, 7)), 12'd0}
                           | $urandom_range(0, 63);
        return $urandom;
    endfunction

    task automatic random_phase(int count);
        repeat (count) send_access(1'($urandom_range(0, 1)), pick_addr());
    endtask

    // Receiver: random stall per word, plus a long hold-off on request.
    initial
    begin
        int gap;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            gap = no_gaps ? 0 : $urandom_range(0, 13);
            if (hold_off)
            begin
                gap = 300;
                hold_off = 0;
            end
            if (gap != 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            sb.check_result(out_data);
        end
    end

    // Watchdog: fail if nothing moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || stim_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        sb = new();
        rst_n = 1'b0; in_valid = 1'b0; in_data = '0;
        cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        idle_cycles = 0; stim_done = 0; hold_off = 0; no_gaps = 0;
        for (int k = 0; k < 16; k++) hot_addrs[k] = $urandom;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, both paths, hit after miss, wrap of offset.
        send_access(0, 32'h0000_0000);
        send_access(0, 32'h0000_0000);
        send_access(1, 32'hFFFF_FFFF);
        send_access(1, 32'hFFFF_FFFF);
        send_access(0, 32'hFFFF_FFFF);
        send_access(1, 32'h0000_0000);
        // Fill one L2 set past its ways with inclusive back-invalidation.
        drain();
        write_reg(tlc_pkg::CFG_INCLUSIVE, 10'd1);
        for (int k = 0; k < 10; k++) send_access(k[0], {k[22:0], 9'd0} << 6);
        send_access(0, 32'h0);
        send_access(1, 32'h8000);
        // Extreme timings, level disables, zero offset.
        drain();
        write_reg(tlc_pkg::CFG_L1I_HIT_TIME, 10'd255);
        write_reg(tlc_pkg::CFG_L1D_HIT_TIME, 10'd255);
        write_reg(tlc_pkg::CFG_L2_HIT_TIME, 10'd255);
        write_reg(tlc_pkg::CFG_MEM_LATENCY, 10'd1023);
        write_reg(tlc_pkg::CFG_BLOCK_OFFSET, 10'd0);
        send_access(0, 32'h1234_5678);
        send_access(1, 32'h1234_5678);
        drain();
        write_reg(tlc_pkg::CFG_LEVEL_ENABLE, 10'd0);
        send_access(0, 32'hAAAA_5555);
        drain();
        write_reg(tlc_pkg::CFG_LEVEL_ENABLE, 10'd4);
        send_access(1, 32'h5555_AAAA);
        drain();
        write_reg(tlc_pkg::CFG_LEVEL_ENABLE, 10'd3);
        send_access(0, 32'h5555_AAAA);
        send_access(1, 32'h5555_AAAA);
        drain();

        // Random phases through several settings; long receiver hold-off first.
        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(tlc_pkg::CFG_L1I_HIT_TIME,
                      (ph == 1) ? 10'd0 : 10'($urandom_range(0, 255)));
            write_reg(tlc_pkg::CFG_L1D_HIT_TIME,
                      (ph == 1) ? 10'd0 : 10'($urandom_range(0, 255)));
            write_reg(tlc_pkg::CFG_L2_HIT_TIME,
                      (ph == 1) ? 10'd0 : 10'($urandom_range(0, 255)));
            write_reg(tlc_pkg::CFG_MEM_LATENCY,
                      (ph == 1) ? 10'd0 : 10'($urandom_range(0, 1023)));
            write_reg(tlc_pkg::CFG_INCLUSIVE, ph[0] ? 10'd0 : 10'd1);
            write_reg(tlc_pkg::CFG_BLOCK_OFFSET,
                      (ph == 2) ? 10'd7 : 10'($urandom_range(0, 7)));
            write_reg(tlc_pkg::CFG_LEVEL_ENABLE,
                      (ph < 3) ? 10'd7 : 10'($urandom_range(0, 7)));
            no_gaps = (ph == 4);
            if (ph == 0) hold_off = 1;
            random_phase(210);
            drain();
        end
        stim_done = 1;

        if (sb.mismatches == 0 && sb.pending_words.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
